@@ rtl/lbs_pkg.sv @@
// Shared types, operation codes and fixed-point helpers of the skinning core.
package lbs_pkg;

  localparam int unsigned MaxBonesDefault = 64;
  localparam int unsigned FracBitsDefault = 16;

  // Operation codes of an input transaction
  localparam logic [1:0] OpLoad      = 2'd0;
  localparam logic [1:0] OpEnable    = 2'd1;
  localparam logic [1:0] OpInfluence = 2'd2;

  // Register byte offsets (bit 2 of paddr selects the register word)
  localparam int unsigned PaddrW     = 3;
  localparam logic        RegBoneCnt = 1'b0;

  localparam logic [16:0] WeightOne      = 17'd65536;
  localparam logic [23:0] WeightTotalMax = 24'hFFFFFF;
  localparam logic [23:0] NormalScale    = 24'd32767;

  typedef struct packed {
    logic [1:0]         operation;
    logic [6:0]         slot;
    logic [3:0]         matrix_element;
    logic signed [31:0] matrix_value;
    logic [16:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] rest_normal_x;
    logic signed [15:0] rest_normal_y;
    logic signed [15:0] rest_normal_z;
    logic               last_influence;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_normal_x;
    logic signed [31:0] out_normal_y;
    logic signed [31:0] out_normal_z;
    logic               normal_updated;
  } rsp_t;

  // Round a product to nearest, ties toward plus infinity, dropping f bits
  function automatic logic signed [63:0] round_fx(input logic signed [63:0] p,
                                                  input int unsigned f);
    logic signed [63:0] half;
    half = 64'sd1 <<< (f - 1);
    return (p + half) >>> f;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ rtl/lbs_if.sv @@
// Valid/ready channel interfaces for input and result transactions.
interface lbs_req_if;
  logic          valid;
  logic          ready;
  lbs_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbs_rsp_if;
  logic          valid;
  logic          ready;
  lbs_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lbs_mxu.sv @@
// Matrix memory and 3x4 matrix-vector engine on one read port and one multiplier.
module lbs_mxu #(
  parameter  int unsigned MAX_BONES     = 64,
  parameter  int unsigned FRACTION_BITS = 16,
  localparam int unsigned SlotW         = $clog2(MAX_BONES + 2),
  localparam int unsigned AddrW         = SlotW + 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  logic signed [31:0]   wr_data_i,
  input  logic                 start_i,
  input  logic [SlotW-1:0]     slot_i,
  input  logic signed [31:0]   vec_i [3],
  input  logic                 affine_i,
  output logic                 done_o,
  output logic signed [31:0]   res_o [3]
);
  import lbs_pkg::*;

  localparam int unsigned Depth = (MAX_BONES + 2) * 16;
  localparam logic [3:0]  LastElem = 4'd11;

  logic signed [31:0] mem_q [Depth];
  logic signed [31:0] rd_q;
  logic [SlotW-1:0]   slot_q;
  logic signed [31:0] vec_q [3];
  logic               aff_q;
  logic               issue_q;
  logic [3:0]         elem_q;
  logic               s1_vld_q, s2_vld_q;
  logic [3:0]         s1_elem_q, s2_elem_q;
  logic signed [63:0] prod_q, acc_q, acc_sum;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [31:0] res_q [3];
  logic               done_q;

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[{slot_q, elem_q}];
  end

  // Pick the vector component for the column being multiplied
  always_comb begin
    case (s1_elem_q[1:0])
      2'd0:    mul_b = vec_q[0];
      2'd1:    mul_b = vec_q[1];
      2'd2:    mul_b = vec_q[2];
      default: mul_b = '0;
    endcase
  end

  assign mul_p   = rd_q * mul_b;
  assign acc_sum = acc_q + round_fx(prod_q, FRACTION_BITS);

  // Sequence the twelve word reads and track them down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= 1'b0;
      elem_q   <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (start_i) begin
        issue_q <= 1'b1;
        elem_q  <= '0;
      end else if (issue_q) begin
        elem_q <= elem_q + 4'd1;
        if (elem_q == LastElem) begin
          issue_q <= 1'b0;
        end
      end
      s1_vld_q <= issue_q;
      s2_vld_q <= s1_vld_q;
      done_q   <= s2_vld_q && (s2_elem_q == LastElem);
    end
  end

  // Multiply, then accumulate each row and saturate it
  always_ff @(posedge clk_i) begin
    s1_elem_q <= elem_q;
    s2_elem_q <= s1_elem_q;
    if (start_i) begin
      slot_q <= slot_i;
      vec_q  <= vec_i;
      aff_q  <= affine_i;
      acc_q  <= '0;
    end
    if (s1_vld_q) begin
      if (s1_elem_q[1:0] == 2'd3) begin
        prod_q <= aff_q ? (64'(rd_q) <<< FRACTION_BITS) : 64'sd0;
      end else begin
        prod_q <= mul_p;
      end
    end
    if (s2_vld_q) begin
      if (s2_elem_q[1:0] == 2'd3) begin
        acc_q <= '0;
        case (s2_elem_q[3:2])
          2'd0:    res_q[0] <= sat32(66'(acc_sum));
          2'd1:    res_q[1] <= sat32(66'(acc_sum));
          default: res_q[2] <= sat32(66'(acc_sum));
        endcase
      end else begin
        acc_q <= acc_sum;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/lbs_div.sv @@
// Bit-serial rounding divider with a signed 32-bit saturated quotient.
module lbs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [23:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  import lbs_pkg::*;

  localparam logic [2:0] DvIdle = 3'd0;
  localparam logic [2:0] DvAdd  = 3'd1;
  localparam logic [2:0] DvChk  = 3'd2;
  localparam logic [2:0] DvRun  = 3'd3;
  localparam logic [2:0] DvFin  = 3'd4;

  logic [2:0]         st_q;
  logic [4:0]         cnt_q;
  logic               done_q;
  logic               neg_q, ovf_q;
  logic [63:0]        mag_q;
  logic [23:0]        den_q, rem_q;
  logic [31:0]        low_q, quo_q;
  logic signed [31:0] res_q;
  logic [24:0]        trial, diff;
  logic               fits;

  assign trial = {rem_q, low_q[31]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  // Sequence: add half divisor, range check, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DvIdle;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        DvIdle: if (start_i) st_q <= DvAdd;
        DvAdd:  st_q <= DvChk;
        DvChk: begin
          cnt_q <= 5'd31;
          st_q  <= (mag_q[63:32] >= 32'(den_q)) ? DvFin : DvRun;
        end
        DvRun: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) st_q <= DvFin;
        end
        DvFin: begin
          done_q <= 1'b1;
          st_q   <= DvIdle;
        end
        default: st_q <= DvIdle;
      endcase
    end
  end

  // Datapath of the divider
  always_ff @(posedge clk_i) begin
    case (st_q)
      DvIdle: begin
        if (start_i) begin
          neg_q <= num_i[63];
          mag_q <= num_i[63] ? 64'(-num_i) : 64'(num_i);
          den_q <= den_i;
        end
      end
      DvAdd: mag_q <= mag_q + 64'(den_q[23:1]);
      DvChk: begin
        ovf_q <= mag_q[63:32] >= 32'(den_q);
        rem_q <= mag_q[55:32];
        low_q <= mag_q[31:0];
      end
      DvRun: begin
        rem_q <= fits ? diff[23:0] : trial[23:0];
        low_q <= {low_q[30:0], 1'b0};
        quo_q <= {quo_q[30:0], fits};
      end
      DvFin: begin
        if (ovf_q) begin
          res_q <= neg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else if (!neg_q) begin
          res_q <= quo_q[31] ? 32'sh7FFFFFFF : $signed(quo_q);
        end else begin
          res_q <= (quo_q > 32'h80000000) ? 32'sh80000000 : $signed(-quo_q);
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

@@ rtl/linear_blend_skinning_core.sv @@
// Skinning core top level: sequencer, accumulators, enables, APB and output register.
//
// Linear blend skinning core. Transactions carry one of three operations: a
// matrix word load, a bone enable write, or an influence. An influence runs
// the pre matrix and, when counted, the bone matrix on the matrix memory,
// which delivers one word per cycle to a single multiplier, plus the weighted
// displacement step. The last influence of a vertex adds the vertex end: three
// rest normal scalings, and when some influence counted three offset divisions
// by the weight total on a bit-serial divider, then the bone normal transform;
// the post transform always follows. The next transaction is taken while a
// finished result waits in the output register. Matrix words are undefined
// until loaded; there is no clearing pass. bone_count sits at byte offset 0.
module linear_blend_skinning_core #(
  parameter int unsigned MAX_BONES     = lbs_pkg::MaxBonesDefault,
  parameter int unsigned FRACTION_BITS = lbs_pkg::FracBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lbs_req_if.sink                    req_i,
  lbs_rsp_if.source                  rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbs_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lbs_pkg::*;

  localparam int unsigned SlotW = $clog2(MAX_BONES + 2);
  localparam int unsigned BoneW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int unsigned AddrW = SlotW + 4;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StPre  = 4'd1;
  localparam logic [3:0] StBone = 4'd2;
  localparam logic [3:0] StDisp = 4'd3;
  localparam logic [3:0] StAcc  = 4'd4;
  localparam logic [3:0] StDivn = 4'd5;
  localparam logic [3:0] StDivs = 4'd6;
  localparam logic [3:0] StNrm  = 4'd7;
  localparam logic [3:0] StPost = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  logic [3:0]          state_q, state_d;
  logic                go_q, go_d;
  logic [1:0]          idx_q, idx_d;
  logic [6:0]          bone_count_q;
  logic [MAX_BONES-1:0] en_q;
  req_t                req_q;
  logic [16:0]         w_q;
  logic                cnt_q;
  logic signed [31:0]  co_q [3];
  logic signed [31:0]  t_q [3];
  logic signed [31:0]  nrm_q [3];
  logic signed [50:0]  prod_q [3];
  logic signed [63:0]  sum_q [3];
  logic [23:0]         wt_q;
  logic signed [17:0]  sw_q;
  logic [BoneW-1:0]    sb_q;
  logic                out_vld_q;
  rsp_t                out_q;

  logic                acc;
  logic [15:0]         in_slot, cur_slot;
  logic [8:0]          limit;
  logic [16:0]         w_sat;
  logic                counted;
  logic                cfg_wr;
  logic [24:0]         wt_sum;
  logic signed [64:0]  s_ext [3];

  logic                mx_we, mx_start, mx_done, mx_aff;
  logic [AddrW-1:0]    mx_waddr;
  logic [SlotW-1:0]    mx_slot;
  logic signed [31:0]  mx_vec [3];
  logic signed [31:0]  mx_res [3];
  logic signed [31:0]  pos [3];

  logic                dv_start, dv_done;
  logic signed [63:0]  dv_num;
  logic [23:0]         dv_den;
  logic signed [31:0]  dv_quot;
  logic signed [15:0]  rn_sel;

  logic [15:0]         rn_mag;
  logic [39:0]         rn_num;
  logic [25:0]         rn_fold;
  logic [15:0]         rn_tail;
  logic [25:0]         rn_quo;
  logic signed [31:0]  rn_scaled;

  // Input handshake and decode
  assign acc      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == StIdle);
  assign in_slot  = 16'(req_i.data.slot);
  assign cur_slot = 16'(req_q.slot);
  assign limit    = (9'(bone_count_q) < 9'(MAX_BONES)) ? 9'(bone_count_q) : 9'(MAX_BONES);
  assign w_sat    = (req_i.data.weight > WeightOne) ? WeightOne : req_i.data.weight;
  assign counted  = (in_slot < 16'(limit)) && en_q[in_slot[BoneW-1:0]] && (w_sat != '0);

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegBoneCnt);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegBoneCnt) ? 32'(bone_count_q) : 32'd0;

  // Matrix word loads go straight into the memory
  assign mx_we    = acc && (req_i.data.operation == OpLoad) &&
                    (in_slot < 16'(MAX_BONES + 2));
  assign mx_waddr = {in_slot[SlotW-1:0], req_i.data.matrix_element};

  assign pos[0] = req_q.pos_x;
  assign pos[1] = req_q.pos_y;
  assign pos[2] = req_q.pos_z;

  // Select matrix slot and vector for the current pass
  always_comb begin
    mx_slot = SlotW'(MAX_BONES);
    mx_vec  = pos;
    mx_aff  = 1'b1;
    case (state_q)
      StBone: begin
        mx_slot = cur_slot[SlotW-1:0];
        mx_vec  = co_q;
      end
      StNrm: begin
        mx_slot = SlotW'(sb_q);
        mx_vec  = nrm_q;
        mx_aff  = 1'b0;
      end
      StPost: begin
        mx_slot = SlotW'(MAX_BONES + 1);
        mx_vec  = co_q;
      end
      default: ;
    endcase
  end

  assign mx_start = go_q && ((state_q == StPre) || (state_q == StBone) ||
                             (state_q == StNrm) || (state_q == StPost));

  lbs_mxu #(
    .MAX_BONES     (MAX_BONES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mxu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mx_we),
    .wr_addr_i (mx_waddr),
    .wr_data_i (req_i.data.matrix_value),
    .start_i   (mx_start),
    .slot_i    (mx_slot),
    .vec_i     (mx_vec),
    .affine_i  (mx_aff),
    .done_o    (mx_done),
    .res_o     (mx_res)
  );

  // Select the rest normal component for the current scaling step
  always_comb begin
    case (idx_q)
      2'd0:    rn_sel = req_q.rest_normal_x;
      2'd1:    rn_sel = req_q.rest_normal_y;
      default: rn_sel = req_q.rest_normal_z;
    endcase
  end

  // Scale the rest normal by 2^F / 32767, rounding half away from zero.
  // 2^15 is one above the divisor, so fold 15-bit chunks instead of dividing.
  always_comb begin
    rn_mag    = rn_sel[15] ? 16'(-rn_sel) : 16'(rn_sel);
    rn_num    = (40'(rn_mag) << FRACTION_BITS) + 40'(NormalScale[23:1]);
    rn_fold   = 26'(rn_num[39:15]) + 26'(rn_num[14:0]);
    rn_tail   = 16'(rn_fold[25:15]) + 16'(rn_fold[14:0]);
    rn_quo    = 26'(rn_num[39:15]) + 26'(rn_fold[25:15]) +
                26'(rn_tail >= 16'(NormalScale));
    rn_scaled = rn_sel[15] ? -32'(rn_quo) : 32'(rn_quo);
  end

  // Divide each offset sum by the weight total
  assign dv_num   = sum_q[idx_q];
  assign dv_den   = wt_q;
  assign dv_start = go_q && (state_q == StDivs);

  lbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quot_o  (dv_quot)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    idx_d   = idx_q;
    unique case (state_q)
      StIdle: begin
        if (acc && (req_i.data.operation == OpInfluence)) begin
          state_d = StPre;
          go_d    = 1'b1;
        end
      end
      StPre: begin
        if (mx_done) begin
          if (cnt_q) begin
            state_d = StBone;
            go_d    = 1'b1;
          end else if (req_q.last_influence) begin
            state_d = StDivn;
            idx_d   = 2'd0;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StBone: if (mx_done) state_d = StDisp;
      StDisp: state_d = StAcc;
      StAcc: begin
        if (req_q.last_influence) begin
          state_d = StDivn;
          idx_d   = 2'd0;
        end else begin
          state_d = StIdle;
        end
      end
      StDivn: begin
        if (idx_q == 2'd2) begin
          idx_d   = 2'd0;
          go_d    = 1'b1;
          state_d = (wt_q != '0) ? StDivs : StPost;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      StDivs: begin
        if (dv_done) begin
          go_d = 1'b1;
          if (idx_q == 2'd2) begin
            idx_d   = 2'd0;
            state_d = StNrm;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      StNrm: begin
        if (mx_done) begin
          state_d = StPost;
          go_d    = 1'b1;
        end
      end
      StPost: if (mx_done) state_d = StOut;
      StOut:  if (!out_vld_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Saturating sums for the accumulate step
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_ext[i] = 65'(sum_q[i]) + 65'(prod_q[i]);
    end
    wt_sum = 25'(wt_q) + 25'(w_q);
  end

  // Control, enables and per-vertex accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      go_q         <= 1'b0;
      idx_q        <= '0;
      bone_count_q <= '0;
      en_q         <= '0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
      wt_q         <= '0;
      sw_q         <= -18'sd1;
      sb_q         <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      idx_q   <= idx_d;
      if (cfg_wr) bone_count_q <= pwdata[6:0];
      if (acc && (req_i.data.operation == OpEnable) && (in_slot < 16'(MAX_BONES))) begin
        en_q[in_slot[BoneW-1:0]] <= req_i.data.matrix_value[0];
      end
      if (rsp_o.valid && rsp_o.ready) out_vld_q <= 1'b0;
      if (state_q == StAcc) begin
        for (int i = 0; i < 3; i++) begin
          if (s_ext[i] > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
            sum_q[i] <= 64'sh7FFF_FFFF_FFFF_FFFF;
          end else if (s_ext[i] < -65'sh0_7FFF_FFFF_FFFF_FFFF) begin
            sum_q[i] <= -64'sh7FFF_FFFF_FFFF_FFFF;
          end else begin
            sum_q[i] <= s_ext[i][63:0];
          end
        end
        wt_q <= (wt_sum > 25'(WeightTotalMax)) ? WeightTotalMax : wt_sum[23:0];
        if ($signed({1'b0, w_q}) > sw_q) begin
          sw_q <= $signed({1'b0, w_q});
          sb_q <= cur_slot[BoneW-1:0];
        end
      end
      // Hand the result over and clear the vertex
      if ((state_q == StOut) && !out_vld_q) begin
        out_vld_q <= 1'b1;
        for (int i = 0; i < 3; i++) sum_q[i] <= '0;
        wt_q <= '0;
        sw_q <= -18'sd1;
        sb_q <= '0;
      end
    end
  end

  // Vertex datapath registers
  always_ff @(posedge clk_i) begin
    if (acc && (req_i.data.operation == OpInfluence)) begin
      req_q <= req_i.data;
      w_q   <= w_sat;
      cnt_q <= counted;
    end
    case (state_q)
      StPre:  if (mx_done) co_q <= mx_res;
      StBone: if (mx_done) t_q <= mx_res;
      StDisp: begin
        for (int i = 0; i < 3; i++) begin
          prod_q[i] <= (33'(t_q[i]) - 33'(co_q[i])) * $signed({1'b0, w_q});
        end
      end
      StDivn: nrm_q[idx_q] <= rn_scaled;
      StDivs: if (dv_done) co_q[idx_q] <= sat32(66'(co_q[idx_q]) + 66'(dv_quot));
      StNrm:  if (mx_done) nrm_q <= mx_res;
      StOut: begin
        if (!out_vld_q) begin
          out_q.out_x          <= mx_res[0];
          out_q.out_y          <= mx_res[1];
          out_q.out_z          <= mx_res[2];
          out_q.out_normal_x   <= nrm_q[0];
          out_q.out_normal_y   <= nrm_q[1];
          out_q.out_normal_z   <= nrm_q[2];
          out_q.normal_updated <= (wt_q != '0);
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

endmodule
